[src/pid_position_controller_core_assert.svh]
// ----------------------------------------------------------------------------
// PID position controller assertion macros
// Concurrent checks on a clock with an active-low synchronous reset.
// ----------------------------------------------------------------------------
`ifndef PID_POSITION_CONTROLLER_CORE_ASSERT_SVH
`define PID_POSITION_CONTROLLER_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// Check that a property holds at every clock edge out of reset.
`define PIDPC_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("pidpc assertion failed");

// Check that a condition never holds out of reset.
`define PIDPC_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
        else $error("pidpc forbidden condition seen");

`else

`define PIDPC_ASSERT(label, clk, rst_n, prop)
`define PIDPC_NEVER(label, clk, rst_n, cond)

`endif

`endif

[src/pidpc_pkg.sv]
// ----------------------------------------------------------------------------
// PID position controller package
// Widths, reset values, register indexes, controller types and clamp helper.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pidpc_pkg;

    // Field and register widths
    localparam int ANGLE_W   = 16;
    localparam int ERR_W     = ANGLE_W + 1;
    localparam int REG_W     = 16;
    localparam int CFG_IDX_W = 3;

    // Multiplier: 18 bit signed by 17 bit signed
    localparam int MUL_A_W = ERR_W + 1;
    localparam int MUL_B_W = REG_W + 1;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    // Derivative term is split into a low unsigned half and a high signed half
    localparam int DLO_W = MUL_A_W - 1;
    localparam int ACC_W = 52;

    localparam int PERIOD_FRAC = 16;
    localparam int GAIN_FRAC   = 8;
    localparam int INC_W       = PROD_W - PERIOD_FRAC;
    localparam int ISUM_W      = INC_W + 1;
    localparam int CLAMP_W     = ACC_W - GAIN_FRAC;

    // Register reset values
    localparam logic [REG_W-1:0]        GAIN_P_RST        = 16'd384;
    localparam logic [REG_W-1:0]        GAIN_I_RST        = 16'd26;
    localparam logic [REG_W-1:0]        GAIN_D_RST        = 16'd0;
    localparam logic signed [REG_W-1:0] OUT_MIN_RST       = -16'sd12868;
    localparam logic signed [REG_W-1:0] OUT_MAX_RST       = 16'sd12868;
    localparam logic [REG_W-1:0]        SAMPLE_PERIOD_RST = 16'd655;
    localparam logic [REG_W-1:0]        SAMPLE_RATE_RST   = 16'd100;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN_P        = 3'd0,
        CFG_GAIN_I        = 3'd1,
        CFG_GAIN_D        = 3'd2,
        CFG_OUT_MIN       = 3'd3,
        CFG_OUT_MAX       = 3'd4,
        CFG_SAMPLE_PERIOD = 3'd5,
        CFG_SAMPLE_RATE   = 3'd6
    } t_cfg_idx;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INC,
        ST_DER,
        ST_P,
        ST_I,
        ST_DLO,
        ST_DHI,
        ST_SUM,
        ST_DONE
    } t_state;

    typedef enum logic [2:0] {
        MUL_INC,
        MUL_DER,
        MUL_P,
        MUL_I,
        MUL_DLO,
        MUL_DHI
    } t_mul_sel;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_ADD,
        ACC_ADD_HI
    } t_acc_op;

    typedef struct packed {
        logic     load_in;
        logic     mul_en;
        t_mul_sel mul_sel;
        logic     upd_integ;
        logic     ld_deriv;
        t_acc_op  acc_op;
        logic     ld_out;
    } t_cmd;

    // Limit from above by hi, then from below by lo
    function automatic logic signed [ANGLE_W-1:0] clamp_limits(
        input logic signed [CLAMP_W-1:0] v,
        input logic signed [REG_W-1:0]   lo,
        input logic signed [REG_W-1:0]   hi
    );
        logic signed [CLAMP_W-1:0] t;
        t = v;
        if (t > CLAMP_W'(hi)) begin
            t = CLAMP_W'(hi);
        end
        if (t < CLAMP_W'(lo)) begin
            t = CLAMP_W'(lo);
        end
        return t[ANGLE_W-1:0];
    endfunction

endpackage

`default_nettype wire

[src/pidpc_if.sv]
// ----------------------------------------------------------------------------
// PID position controller channels
// Sample input, result output and register write channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface pidpc_in_if;
    logic                                      valid;
    logic                                      ready;
    logic signed [pidpc_pkg::ANGLE_W-1:0]      setpoint;
    logic signed [pidpc_pkg::ANGLE_W-1:0]      measured;

    modport source (output valid, output setpoint, output measured, input ready);
    modport sink   (input valid, input setpoint, input measured, output ready);
endinterface

interface pidpc_out_if;
    logic                                      valid;
    logic                                      ready;
    logic signed [pidpc_pkg::ANGLE_W-1:0]      drive;
    logic signed [pidpc_pkg::ERR_W-1:0]        error;

    modport source (output valid, output drive, output error, input ready);
    modport sink   (input valid, input drive, input error, output ready);
endinterface

interface pidpc_cfg_if;
    logic                                      valid;
    logic                                      ready;
    logic [pidpc_pkg::CFG_IDX_W-1:0]           index;
    logic [pidpc_pkg::REG_W-1:0]               data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[src/pidpc_ctrl.sv]
// ----------------------------------------------------------------------------
// PID position controller sequencer
// Steps the shared multiplier and accumulator through one sample.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "pid_position_controller_core_assert.svh"

module pidpc_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output pidpc_pkg::t_cmd o_cmd
);
    import pidpc_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   w_out_free;

    assign w_out_free  = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.ld_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_INC;
            end
            ST_INC:  n_state = ST_DER;
            ST_DER:  n_state = ST_P;
            ST_P:    n_state = ST_I;
            ST_I:    n_state = ST_DLO;
            ST_DLO:  n_state = ST_DHI;
            ST_DHI:  n_state = ST_SUM;
            ST_SUM:  n_state = ST_DONE;
            ST_DONE: begin
                if (w_out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready       = 1'b0;
        o_cmd            = '0;
        o_cmd.mul_sel    = MUL_INC;
        o_cmd.acc_op     = ACC_HOLD;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.load_in = i_in_valid;
            end
            ST_INC: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_INC;
            end
            ST_DER: begin
                o_cmd.mul_en    = 1'b1;
                o_cmd.mul_sel   = MUL_DER;
                o_cmd.upd_integ = 1'b1;
            end
            ST_P: begin
                o_cmd.ld_deriv = 1'b1;
                o_cmd.mul_en   = 1'b1;
                o_cmd.mul_sel  = MUL_P;
            end
            ST_I: begin
                o_cmd.acc_op  = ACC_LOAD;
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_I;
            end
            ST_DLO: begin
                o_cmd.acc_op  = ACC_ADD;
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_DLO;
            end
            ST_DHI: begin
                o_cmd.acc_op  = ACC_ADD;
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_DHI;
            end
            ST_SUM: begin
                o_cmd.acc_op = ACC_ADD_HI;
            end
            ST_DONE: begin
                o_cmd.ld_out = w_out_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    `PIDPC_ASSERT(a_accept_starts, i_clk, i_rst_n, (r_state == ST_IDLE && i_in_valid) |=> (r_state == ST_INC))
    `PIDPC_ASSERT(a_valid_from_done, i_clk, i_rst_n, $rose(r_out_valid) |-> $past(r_state == ST_DONE))
    `PIDPC_ASSERT(a_done_waits, i_clk, i_rst_n, (r_state == ST_DONE && r_out_valid && !i_out_ready) |=> (r_state == ST_DONE && r_out_valid))
    `PIDPC_NEVER(a_no_accept_busy, i_clk, i_rst_n, o_in_ready && r_state != ST_IDLE)

endmodule

`default_nettype wire

[src/pidpc_datapath.sv]
// ----------------------------------------------------------------------------
// PID position controller datapath
// Registers, shared multiplier, accumulator, rounding and clamps.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pidpc_datapath (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  pidpc_pkg::t_cmd                       i_cmd,
    input  logic signed [pidpc_pkg::ANGLE_W-1:0]  i_setpoint,
    input  logic signed [pidpc_pkg::ANGLE_W-1:0]  i_measured,
    input  logic                                  i_cfg_we,
    input  logic [pidpc_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [pidpc_pkg::REG_W-1:0]           i_cfg_data,
    output logic signed [pidpc_pkg::ANGLE_W-1:0]  o_drive,
    output logic signed [pidpc_pkg::ERR_W-1:0]    o_error
);
    import pidpc_pkg::*;

    // Configuration
    logic [REG_W-1:0]        r_gain_p;
    logic [REG_W-1:0]        r_gain_i;
    logic [REG_W-1:0]        r_gain_d;
    logic signed [REG_W-1:0] r_out_min;
    logic signed [REG_W-1:0] r_out_max;
    logic [REG_W-1:0]        r_period;
    logic [REG_W-1:0]        r_rate;

    // Loop state
    logic signed [ANGLE_W-1:0] r_integ;
    logic signed [ERR_W-1:0]   r_prev;

    // Working registers
    logic signed [ERR_W-1:0]   r_err;
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [PROD_W-1:0]  r_deriv;
    logic signed [ACC_W-1:0]   r_acc;
    logic signed [ANGLE_W-1:0] r_drive;
    logic signed [ERR_W-1:0]   r_error;

    logic signed [MUL_A_W-1:0] w_mul_a;
    logic signed [MUL_B_W-1:0] w_mul_b;
    logic signed [MUL_A_W-1:0] w_diff;
    logic signed [PROD_W-1:0]  n_prod;
    logic signed [PROD_W-1:0]  w_inc_biased;
    logic signed [INC_W-1:0]   w_inc;
    logic signed [ISUM_W-1:0]  w_isum;
    logic signed [ACC_W-1:0]   w_acc_biased;
    logic signed [CLAMP_W-1:0] w_acc_rnd;
    logic signed [ACC_W-1:0]   n_acc;

    assign w_diff = MUL_A_W'(r_err) - MUL_A_W'(r_prev);

    // Operand select for the shared multiplier
    always_comb begin
        w_mul_a = MUL_A_W'(r_err);
        w_mul_b = MUL_B_W'(r_period);
        case (i_cmd.mul_sel)
            MUL_INC: begin
                w_mul_a = MUL_A_W'(r_err);
                w_mul_b = MUL_B_W'(r_period);
            end
            MUL_DER: begin
                w_mul_a = w_diff;
                w_mul_b = MUL_B_W'(r_rate);
            end
            MUL_P: begin
                w_mul_a = MUL_A_W'(r_err);
                w_mul_b = MUL_B_W'(r_gain_p);
            end
            MUL_I: begin
                w_mul_a = MUL_A_W'(r_integ);
                w_mul_b = MUL_B_W'(r_gain_i);
            end
            MUL_DLO: begin
                w_mul_a = {1'b0, r_deriv[DLO_W-1:0]};
                w_mul_b = MUL_B_W'(r_gain_d);
            end
            MUL_DHI: begin
                w_mul_a = r_deriv[PROD_W-1:DLO_W];
                w_mul_b = MUL_B_W'(r_gain_d);
            end
            default: begin
                w_mul_a = MUL_A_W'(r_err);
                w_mul_b = MUL_B_W'(r_period);
            end
        endcase
    end

    assign n_prod = w_mul_a * w_mul_b;

    // Integral increment, rounded half up, then clamped sum
    assign w_inc_biased = r_prod + PROD_W'(1 << (PERIOD_FRAC - 1));
    assign w_inc        = w_inc_biased[PROD_W-1:PERIOD_FRAC];
    assign w_isum       = ISUM_W'(r_integ) + ISUM_W'(w_inc);

    // Drive rounding
    assign w_acc_biased = r_acc + ACC_W'(1 << (GAIN_FRAC - 1));
    assign w_acc_rnd    = w_acc_biased[ACC_W-1:GAIN_FRAC];

    always_comb begin
        n_acc = r_acc;
        case (i_cmd.acc_op)
            ACC_HOLD:   n_acc = r_acc;
            ACC_LOAD:   n_acc = ACC_W'(r_prod);
            ACC_ADD:    n_acc = r_acc + ACC_W'(r_prod);
            ACC_ADD_HI: n_acc = r_acc + (ACC_W'(r_prod) <<< DLO_W);
            default:    n_acc = r_acc;
        endcase
    end

    // Configuration and loop state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_p  <= GAIN_P_RST;
            r_gain_i  <= GAIN_I_RST;
            r_gain_d  <= GAIN_D_RST;
            r_out_min <= OUT_MIN_RST;
            r_out_max <= OUT_MAX_RST;
            r_period  <= SAMPLE_PERIOD_RST;
            r_rate    <= SAMPLE_RATE_RST;
            r_integ   <= '0;
            r_prev    <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_GAIN_P:        r_gain_p  <= i_cfg_data;
                    CFG_GAIN_I:        r_gain_i  <= i_cfg_data;
                    CFG_GAIN_D:        r_gain_d  <= i_cfg_data;
                    CFG_OUT_MIN:       r_out_min <= i_cfg_data;
                    CFG_OUT_MAX:       r_out_max <= i_cfg_data;
                    CFG_SAMPLE_PERIOD: r_period  <= i_cfg_data;
                    CFG_SAMPLE_RATE:   r_rate    <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (i_cmd.upd_integ) begin
                r_integ <= clamp_limits(CLAMP_W'(w_isum), r_out_min, r_out_max);
            end
            if (i_cmd.ld_out) begin
                r_prev <= r_err;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_err <= ERR_W'(i_setpoint) - ERR_W'(i_measured);
        end
        if (i_cmd.mul_en) begin
            r_prod <= n_prod;
        end
        if (i_cmd.ld_deriv) begin
            r_deriv <= r_prod;
        end
        r_acc <= n_acc;
        if (i_cmd.ld_out) begin
            r_drive <= clamp_limits(w_acc_rnd, r_out_min, r_out_max);
            r_error <= r_err;
        end
    end

    assign o_drive = r_drive;
    assign o_error = r_error;

endmodule

`default_nettype wire

[src/pid_position_controller_core.sv]
// Flow: a sample is taken only in idle, and its result is registered in the
//   done state; one 18x17 multiplier is shared by six products, and a result
//   register lets the next sample enter while one waits.
// Reset: synchronous active-low i_rst_n restores every gain, limit, period and
//   rate register to its default and clears the integral sum and last error.
// ----------------------------------------------------------------------------
// PID position controller core
// Error, clamped integral, derivative and clamped drive per sample.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pid_position_controller_core (
    input  logic         i_clk,
    input  logic         i_rst_n,
    pidpc_in_if.sink     i_in,
    pidpc_out_if.source  o_out,
    pidpc_cfg_if.sink    i_cfg
);
    import pidpc_pkg::*;

    // Command bundle from the sequencer into the datapath
    t_cmd w_cmd;

    // Register writes take effect at once; the port never stalls. The user must
    // issue writes only while no sample is in flight; the block does not enforce it.
    assign i_cfg.ready = 1'b1;

    // Sequencer: idle -> increment product -> derivative product (integral
    // update) -> P, I, D-low, D-high products -> final add -> result load.
    pidpc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_cmd       (w_cmd)
    );

    // Datapath: holds configuration, integral sum and previous error, and
    // drives the result payload registers.
    pidpc_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_setpoint  (i_in.setpoint),
        .i_measured  (i_in.measured),
        .i_cfg_we    (i_cfg.valid),
        .i_cfg_index (i_cfg.index),
        .i_cfg_data  (i_cfg.data),
        .o_drive     (o_out.drive),
        .o_error     (o_out.error)
    );

endmodule

`default_nettype wire
